// ----- rtl/oepd_pkg.sv -----
// ============================================================================
// Optical edge preamble detector package
// Shared payload types, configuration layout and register codes.
// ============================================================================
package oepd_pkg;

    // Widths fixed by the transaction fields.
    localparam int SAMPLE_W   = 10;
    localparam int TIME_W     = 32;
    localparam int INTERVAL_W = 16;
    localparam int WEIGHT_W   = 8;
    localparam int SPREAD_W   = 10;
    localparam int LIMIT_W    = 15;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;
    localparam int RING_DEPTH = 4;

    // Register indexes on the configuration port (byte address / 4).
    typedef enum logic [1:0] {
        REG_DECAY_WEIGHT  = 2'd0,
        REG_ACCEPT_SPREAD = 2'd1,
        REG_MIN_INTERVAL  = 2'd2,
        REG_MAX_INTERVAL  = 2'd3
    } reg_index_t;

    // Register reset values.
    localparam logic [WEIGHT_W-1:0] DECAY_WEIGHT_RST  = 8'd192;
    localparam logic [SPREAD_W-1:0] ACCEPT_SPREAD_RST = 10'd10;
    localparam logic [LIMIT_W-1:0]  MIN_INTERVAL_RST  = 15'd50;
    localparam logic [LIMIT_W-1:0]  MAX_INTERVAL_RST  = 15'd500;

    // Input transaction.
    typedef struct packed {
        logic                action;
        logic [SAMPLE_W-1:0] sample_a;
        logic [SAMPLE_W-1:0] sample_b;
        logic [TIME_W-1:0]   now_ms;
    } in_item_t;

    // Result transaction.
    typedef struct packed {
        logic                         phase_out;
        logic                         edge_seen;
        logic                         preamble_found;
        logic signed [INTERVAL_W-1:0] latest_interval;
    } out_item_t;

    // Configuration registers as seen by the datapath.
    typedef struct packed {
        logic [WEIGHT_W-1:0] decay_weight;
        logic [SPREAD_W-1:0] accept_spread;
        logic [LIMIT_W-1:0]  min_interval;
        logic [LIMIT_W-1:0]  max_interval;
    } cfg_t;

    // Phase stage to interval stage hand-off.
    typedef struct packed {
        logic              action;
        logic              phase;
        logic              edge_seen;
        logic [TIME_W-1:0] now_ms;
    } stage_t;

endpackage

// ----- rtl/oepd_smooth_lane.sv -----
// ============================================================================
// Smoothing lane
// Exponential average of one phototransistor channel:
// avg = (avg * w + (256 - w) * sample) >> 8.
// ============================================================================
module oepd_smooth_lane #(
    parameter int SAMPLE_BITS = 10,
    parameter int RESET_AVG   = 0
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              update,
    input  logic [oepd_pkg::WEIGHT_W-1:0]     decay_weight,
    input  logic [oepd_pkg::SAMPLE_W-1:0]     sample,
    output logic [SAMPLE_BITS-1:0]            avg_next
);

    localparam int ACC_W = SAMPLE_BITS + oepd_pkg::WEIGHT_W + 1;

    logic [SAMPLE_BITS-1:0]        avg_reg;
    logic [SAMPLE_BITS-1:0]        sample_fit;
    logic [oepd_pkg::WEIGHT_W:0]   inv_weight;
    logic [ACC_W-1:0]              acc;

    // Bring the sample to the lane width, then blend it with the old average.
    assign sample_fit = SAMPLE_BITS'(sample);
    assign inv_weight = (oepd_pkg::WEIGHT_W + 1)'(1 << oepd_pkg::WEIGHT_W)
                        - {1'b0, decay_weight};
    assign acc = (ACC_W'(avg_reg) * ACC_W'(decay_weight))
               + (ACC_W'(sample_fit) * ACC_W'(inv_weight));
    assign avg_next = acc[SAMPLE_BITS+oepd_pkg::WEIGHT_W-1:oepd_pkg::WEIGHT_W];

    // Average register, updated once per processed sample transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            avg_reg <= SAMPLE_BITS'(RESET_AVG);
        end else if (update) begin
            avg_reg <= avg_next;
        end
    end

endmodule

// ----- rtl/oepd_interval_merge.sv -----
// ============================================================================
// Interval merge stage
// Combines the lane phase result into the interval history and evaluates
// the preamble condition over the four most recent intervals.
// ============================================================================
module oepd_interval_merge (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  oepd_pkg::stage_t    stage,
    input  oepd_pkg::cfg_t      cfg,
    output oepd_pkg::out_item_t result
);

    localparam int IW    = oepd_pkg::INTERVAL_W;
    localparam int SUM_W = IW + 2;

    // History kept in age order: tap 0 is the newest, the last tap the oldest.
    // The cyclic difference sum does not depend on where the ring starts.
    logic [IW-1:0]               hist_reg  [oepd_pkg::RING_DEPTH];
    logic [IW-1:0]               hist_next [oepd_pkg::RING_DEPTH];
    logic [oepd_pkg::TIME_W-1:0] last_edge_reg;
    logic [oepd_pkg::TIME_W-1:0] elapsed;
    logic [IW-1:0]               diff01, diff21, diff23, diff03;
    logic [SUM_W-1:0]            spread_sum;
    logic [SUM_W-1:0]            spread_limit;
    logic [IW-1:0]               oldest;
    logic                        oldest_ok;
    logic                        found;
    logic                        flag_reg;

    function automatic logic [IW-1:0] abs_diff(input logic [IW-1:0] x,
                                               input logic [IW-1:0] y);
        logic signed [IW:0] d;
        begin
            d = {x[IW-1], x} - {y[IW-1], y};
            abs_diff = d[IW] ? IW'(-d) : d[IW-1:0];
        end
    endfunction

    assign elapsed = stage.now_ms - last_edge_reg;

    // Next history: clear empties it, an edge shifts in the new interval.
    always_comb begin
        for (int i = 0; i < oepd_pkg::RING_DEPTH; i++) begin
            hist_next[i] = hist_reg[i];
        end
        if (stage.action) begin
            for (int i = 0; i < oepd_pkg::RING_DEPTH; i++) begin
                hist_next[i] = '0;
            end
        end else if (stage.edge_seen) begin
            hist_next[0] = elapsed[IW-1:0];
            for (int i = 1; i < oepd_pkg::RING_DEPTH; i++) begin
                hist_next[i] = hist_reg[i-1];
            end
        end
    end

    // Jitter test: sum of neighbor differences around the ring.
    assign diff01 = abs_diff(hist_next[0], hist_next[1]);
    assign diff21 = abs_diff(hist_next[2], hist_next[1]);
    assign diff23 = abs_diff(hist_next[2], hist_next[3]);
    assign diff03 = abs_diff(hist_next[0], hist_next[3]);
    assign spread_sum = SUM_W'(diff01) + SUM_W'(diff21)
                      + SUM_W'(diff23) + SUM_W'(diff03);
    assign spread_limit = SUM_W'({cfg.accept_spread, 2'b00});

    // Range test on the oldest interval; a negative value always fails.
    assign oldest    = hist_next[oepd_pkg::RING_DEPTH-1];
    assign oldest_ok = !oldest[IW-1]
                       && (oldest[IW-2:0] >= cfg.min_interval)
                       && (oldest[IW-2:0] <= cfg.max_interval);
    assign found     = oldest_ok && (spread_sum <= spread_limit);

    // Result of this transaction.
    always_comb begin
        result.phase_out       = stage.phase;
        result.edge_seen       = stage.edge_seen && !stage.action;
        result.latest_interval = hist_next[0];
        if (stage.action) begin
            result.preamble_found = 1'b0;
        end else if (stage.edge_seen) begin
            result.preamble_found = found;
        end else begin
            result.preamble_found = flag_reg;
        end
    end

    // History, edge time and flag registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < oepd_pkg::RING_DEPTH; i++) begin
                hist_reg[i] <= '0;
            end
            last_edge_reg <= '0;
            flag_reg      <= 1'b0;
        end else if (advance) begin
            for (int i = 0; i < oepd_pkg::RING_DEPTH; i++) begin
                hist_reg[i] <= hist_next[i];
            end
            flag_reg <= result.preamble_found;
            if (!stage.action && stage.edge_seen) begin
                last_edge_reg <= stage.now_ms;
            end
        end
    end

endmodule

// ----- rtl/optical_edge_preamble_detector_unit.sv -----
// ============================================================================
// Optical edge preamble detector
// Smooths two phototransistor channels, tracks the phase between them and
// flags a regular run of edge intervals as a preamble.
// ============================================================================
// Usage:
// Sample transactions enter on the s_ channel (valid/ready) as an in_item_t;
// one out_item_t result per transaction leaves on the m_ channel in order.
// A transaction with action set clears the interval history and the flag,
// keeping the averages and the phase.
// Path: a transaction is loaded into the phase stage register when it is
// accepted, and its result then into the output register, which offers it.
// Throughput: one transaction per cycle while m_ready is high. The per-cycle
// limit is the average feedback in each smoothing lane, one multiply-add per channel per cycle.
// When m_ready is low the result holds in the output register and one more
// transaction is still taken into the phase stage; then s_ready drops.
// Reset (aresetn low, synchronous) empties both stages, loads the register
// defaults and the initial averages; no clearing pass follows.
// The APB port writes and reads the four registers at byte offsets 0, 4, 8
// and 12; pready is always high. Registers must change only while idle; the block does not enforce this.
// ============================================================================
module optical_edge_preamble_detector_unit #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Sample channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  oepd_pkg::in_item_t                s_data,
    // Result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output oepd_pkg::out_item_t               m_data,
    // Configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [oepd_pkg::PADDR_W-1:0]      paddr,
    input  logic [oepd_pkg::PDATA_W-1:0]      pwdata,
    output logic [oepd_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);

    oepd_pkg::cfg_t       cfg_reg;
    oepd_pkg::reg_index_t reg_sel;
    logic                 cfg_write;

    logic                 s_accept;
    logic                 out_free;
    logic                 s1_advance;
    logic                 s1_valid_reg;
    oepd_pkg::stage_t     s1_reg;
    oepd_pkg::stage_t     s1_next;
    logic                 phase_reg;
    logic                 new_phase;
    logic                 lane_update;
    logic [SAMPLE_BITS-1:0] avg_a_next;
    logic [SAMPLE_BITS-1:0] avg_b_next;

    logic                 m_valid_reg;
    oepd_pkg::out_item_t  m_data_reg;
    oepd_pkg::out_item_t  merge_result;

    // Configuration register file.
    assign pready    = 1'b1;
    assign reg_sel   = oepd_pkg::reg_index_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.decay_weight  <= oepd_pkg::DECAY_WEIGHT_RST;
            cfg_reg.accept_spread <= oepd_pkg::ACCEPT_SPREAD_RST;
            cfg_reg.min_interval  <= oepd_pkg::MIN_INTERVAL_RST;
            cfg_reg.max_interval  <= oepd_pkg::MAX_INTERVAL_RST;
        end else if (cfg_write) begin
            unique case (reg_sel)
                oepd_pkg::REG_DECAY_WEIGHT: begin
                    cfg_reg.decay_weight <= pwdata[oepd_pkg::WEIGHT_W-1:0];
                end
                oepd_pkg::REG_ACCEPT_SPREAD: begin
                    cfg_reg.accept_spread <= pwdata[oepd_pkg::SPREAD_W-1:0];
                end
                oepd_pkg::REG_MIN_INTERVAL: begin
                    cfg_reg.min_interval <= pwdata[oepd_pkg::LIMIT_W-1:0];
                end
                oepd_pkg::REG_MAX_INTERVAL: begin
                    cfg_reg.max_interval <= pwdata[oepd_pkg::LIMIT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (reg_sel)
            oepd_pkg::REG_DECAY_WEIGHT:  prdata = oepd_pkg::PDATA_W'(cfg_reg.decay_weight);
            oepd_pkg::REG_ACCEPT_SPREAD: prdata = oepd_pkg::PDATA_W'(cfg_reg.accept_spread);
            oepd_pkg::REG_MIN_INTERVAL:  prdata = oepd_pkg::PDATA_W'(cfg_reg.min_interval);
            oepd_pkg::REG_MAX_INTERVAL:  prdata = oepd_pkg::PDATA_W'(cfg_reg.max_interval);
            default:                     prdata = '0;
        endcase
    end

    // Handshake: the output register and the phase stage each hold one
    // transaction, so input is taken while a result waits.
    assign out_free   = !m_valid_reg || m_ready;
    assign s1_advance = s1_valid_reg && out_free;
    assign s_ready    = !s1_valid_reg || out_free;
    assign s_accept   = s_valid && s_ready;
    assign lane_update = s_accept && !s_data.action;

    // One smoothing lane per channel.
    oepd_smooth_lane #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .RESET_AVG   (10)
    ) u_lane_a (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .update       (lane_update),
        .decay_weight (cfg_reg.decay_weight),
        .sample       (s_data.sample_a),
        .avg_next     (avg_a_next)
    );

    oepd_smooth_lane #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .RESET_AVG   (0)
    ) u_lane_b (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .update       (lane_update),
        .decay_weight (cfg_reg.decay_weight),
        .sample       (s_data.sample_b),
        .avg_next     (avg_b_next)
    );

    // Phase decision from the two fresh averages.
    assign new_phase = avg_a_next < avg_b_next;

    always_comb begin
        s1_next.action    = s_data.action;
        s1_next.now_ms    = s_data.now_ms;
        s1_next.phase     = s_data.action ? phase_reg : new_phase;
        s1_next.edge_seen = !s_data.action && (new_phase != phase_reg);
    end

    // Phase state and phase stage register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= 1'b0;
            s1_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                phase_reg    <= s1_next.phase;
                s1_valid_reg <= 1'b1;
            end else if (s1_advance) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_reg <= s1_next;
        end
    end

    // Interval history and preamble decision.
    oepd_interval_merge u_merge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (s1_advance),
        .stage   (s1_reg),
        .cfg     (cfg_reg),
        .result  (merge_result)
    );

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance) begin
            m_data_reg <= merge_result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
